// ===== design/kwl_pkg.sv =====
// kwl_pkg: shared types and constants of the k-weighted loudness meter
// no dependencies
package kwl_pkg;

	localparam int SAMPLE_BITS       = 24;
	localparam int DEF_MAX_CHANNELS  = 8;
	localparam int DEF_SHORT_BLOCKS  = 8;
	localparam int COEF_W            = 32;
	localparam int DATA_W            = 32;
	localparam int CFG_W             = 64;
	localparam int CFG_IDX_W         = 3;
	localparam int FRAMES_W          = 17;
	localparam int CHCNT_W           = 4;
	localparam int POWER_W           = 48;
	localparam int OPER_W            = 33;

	localparam logic [FRAMES_W-1:0] FRAMES_RST  = FRAMES_W'(19200);
	localparam logic [CHCNT_W-1:0]  CHCNT_RST   = CHCNT_W'(2);
	localparam logic [POWER_W-1:0]  INVSCL_RST  = POWER_W'(7330077);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHELF_B0_B1    = 3'd0,
		REG_SHELF_B2_A1    = 3'd1,
		REG_SHELF_A2_HP_B0 = 3'd2,
		REG_HP_B1_B2       = 3'd3,
		REG_HP_A1_A2       = 3'd4,
		REG_BLOCK_FRAMES   = 3'd5,
		REG_CHANNELS       = 3'd6,
		REG_INVERSE_SCALE  = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [2:0]                    channel;
	} in_t;

	typedef struct packed {
		logic [POWER_W-1:0] block_power;
		logic [POWER_W-1:0] short_term_power;
		logic [3:0]         window_fill;
	} out_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ===== design/kwl_mul.sv =====
// kwl_mul: shared registered 33 x 33 signed multiplier
// depends on kwl_pkg
module kwl_mul (
	input  logic                                    clk,
	input  logic signed [kwl_pkg::OPER_W-1:0]       a,
	input  logic signed [kwl_pkg::OPER_W-1:0]       b,
	output logic signed [2*kwl_pkg::OPER_W-1:0]     p_q
);
	import kwl_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// ===== design/kwl_div.sv =====
// kwl_div: restoring divider, one quotient bit per cycle
// depends on kwl_pkg
module kwl_div #(
	parameter int DW = 52,
	parameter int VW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DW-1:0]       dividend,
	input  logic [VW-1:0]       divisor,
	output kwl_pkg::div_ctl_t   status,
	output logic [DW-1:0]       quotient_q
);
	import kwl_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;

	always_comb begin
		trial = {rem_q, quotient_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q      <= '0;
			dvs_q      <= divisor;
			quotient_q <= dividend;
		end else if (busy_q) begin
			if (!diff[VW]) begin
				rem_q      <= diff[VW-1:0];
				quotient_q <= {quotient_q[DW-2:0], 1'b1};
			end else begin
				rem_q      <= trial[VW-1:0];
				quotient_q <= {quotient_q[DW-2:0], 1'b0};
			end
		end
	end

	assign status = '{start: start, busy: busy_q, done: done_q};
endmodule

// ===== design/k_weighted_block_loudness_meter.sv =====
// k_weighted_block_loudness_meter: top level, sequencer around one shared multiplier
// depends on kwl_pkg, kwl_mul, kwl_div
//
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// input     | in_valid / in_stall  | in_data  (sample, channel)
// output    | out_valid / out_stall| out_data (powers, window_fill)
// config    | cfg_we               | cfg_index, cfg_data
//
// a sample runs one multiply/accumulate step per biquad coefficient on the one
// multiplier, rounding per biquad, then the square and the sum update
// a block end adds the channel sums, scales them, updates the history and runs the divider
// reset clears filter delays, sums and counters; history entries stay unset
// a finished result waits in the output register; the next request is taken meanwhile
module k_weighted_block_loudness_meter #(
	parameter int MAX_CHANNELS      = kwl_pkg::DEF_MAX_CHANNELS,
	parameter int SHORT_TERM_BLOCKS = kwl_pkg::DEF_SHORT_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kwl_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kwl_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [kwl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kwl_pkg::CFG_W-1:0]     cfg_data
);
	import kwl_pkg::*;

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int HD_W   = (SHORT_TERM_BLOCKS > 1) ? $clog2(SHORT_TERM_BLOCKS) : 1;
	localparam int FILL_W = $clog2(SHORT_TERM_BLOCKS + 1);
	localparam int SUM_W  = POWER_W + FILL_W;
	localparam int LSH    = (SAMPLE_BITS <= 29) ? 29 - SAMPLE_BITS : 0;
	localparam int RSH    = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;
	localparam int PROD_W = 112;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_BQ_MUL = 12'b000000000010,
		ST_BQ_ACC = 12'b000000000100,
		ST_BQ_RND = 12'b000000001000,
		ST_SQ_MUL = 12'b000000010000,
		ST_SQ_ACC = 12'b000000100000,
		ST_SUM    = 12'b000001000000,
		ST_PW_MUL = 12'b000010000000,
		ST_PW_ACC = 12'b000100000000,
		ST_HIST   = 12'b001000000000,
		ST_DIV    = 12'b010000000000,
		ST_EMIT   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0]    coef_q [5];
	logic [FRAMES_W-1:0] frames_q;
	logic [CHCNT_W-1:0]  chcnt_q;
	logic [POWER_W-1:0]  invscl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) coef_q[i] <= '0;
			frames_q <= FRAMES_RST;
			chcnt_q  <= CHCNT_RST;
			invscl_q <= INVSCL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHELF_B0_B1:    coef_q[0] <= cfg_data;
				REG_SHELF_B2_A1:    coef_q[1] <= cfg_data;
				REG_SHELF_A2_HP_B0: coef_q[2] <= cfg_data;
				REG_HP_B1_B2:       coef_q[3] <= cfg_data;
				REG_HP_A1_A2:       coef_q[4] <= cfg_data;
				REG_BLOCK_FRAMES:   frames_q  <= cfg_data[FRAMES_W-1:0];
				REG_CHANNELS:       chcnt_q   <= cfg_data[CHCNT_W-1:0];
				REG_INVERSE_SCALE:  invscl_q  <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CHCNT_W-1:0]  nch;
	logic [FRAMES_W-1:0] frames_eff;
	logic [COEF_W-1:0]   coefs [10];

	always_comb begin
		if (chcnt_q == '0) nch = CHCNT_W'(1);
		else if (chcnt_q > CHCNT_W'(MAX_CHANNELS)) nch = CHCNT_W'(MAX_CHANNELS);
		else nch = chcnt_q;
		frames_eff = (frames_q == '0) ? FRAMES_W'(1) : frames_q;
		for (int i = 0; i < 5; i++) begin
			coefs[2*i]   = coef_q[i][63:32];
			coefs[2*i+1] = coef_q[i][31:0];
		end
	end

	// datapath state
	logic signed [DATA_W-1:0] dly_q [2][MAX_CHANNELS][4];
	logic [63:0]              csum_q [MAX_CHANNELS];
	logic [FRAMES_W-1:0]      fcnt_q;
	logic [POWER_W-1:0]       hist_q [SHORT_TERM_BLOCKS];
	logic [FILL_W-1:0]        fill_q;
	logic [HD_W-1:0]          head_q;
	logic [SUM_W-1:0]         hsum_q;

	logic [CH_W-1:0]          ch_q;
	logic [CH_W-1:0]          idx_q;
	logic                     stg_q;
	logic [2:0]               k_q;
	logic [1:0]               pp_q;
	logic signed [DATA_W-1:0] xin_q;
	logic signed [63:0]       acc_q;
	logic [63:0]              total_q;
	logic [PROD_W-1:0]        prod_q;
	logic [POWER_W-1:0]       bp_q;
	logic                     out_valid_q;
	out_t                     out_q;

	logic signed [OPER_W-1:0]     mul_a, mul_b;
	logic signed [2*OPER_W-1:0]   mul_p;
	div_ctl_t                     dv_ctl;
	logic [SUM_W-1:0]             dv_quo;
	logic                         dv_start;

	kwl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	kwl_div #(.DW(SUM_W), .VW(FILL_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(hsum_q), .divisor(fill_q),
		.status(dv_ctl), .quotient_q(dv_quo)
	);

	logic                   accept;
	logic signed [63:0]     x_wide;
	logic signed [DATA_W-1:0] x_conv;
	logic signed [DATA_W-1:0] bq_data;
	logic [3:0]             cidx;
	logic signed [64:0]     acc_next;
	logic signed [63:0]     acc_sat;
	logic signed [34:0]     rnd;
	logic signed [DATA_W-1:0] y_sat;
	logic [64:0]            csum_next;
	logic [64:0]            total_next;
	logic [POWER_W-1:0]     bp_c;
	logic [POWER_W-1:0]     evict;
	logic                   out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign dv_start = (state_q == ST_DIV) && !dv_ctl.busy && !dv_ctl.done;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		x_wide = 64'($signed(in_data.sample));
		x_wide = (x_wide <<< LSH) >>> RSH;
		x_conv = x_wide[DATA_W-1:0];
		cidx   = 4'(stg_q) * 4'd5 + 4'(k_q);
		case (k_q)
			3'd0:    bq_data = xin_q;
			3'd1:    bq_data = dly_q[stg_q][ch_q][0];
			3'd2:    bq_data = dly_q[stg_q][ch_q][1];
			3'd3:    bq_data = dly_q[stg_q][ch_q][2];
			default: bq_data = dly_q[stg_q][ch_q][3];
		endcase
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_BQ_MUL: begin
				mul_a = OPER_W'($signed(coefs[cidx]));
				mul_b = OPER_W'(bq_data);
			end
			ST_SQ_MUL: begin
				mul_a = OPER_W'(xin_q);
				mul_b = OPER_W'(xin_q);
			end
			ST_PW_MUL: begin
				mul_a = $signed({1'b0, pp_q[0] ? total_q[63:32] : total_q[31:0]});
				mul_b = $signed({1'b0, pp_q[1] ? {16'b0, invscl_q[47:32]} : invscl_q[31:0]});
			end
			default: ;
		endcase
		if (k_q < 3'd3) acc_next = {acc_q[63], acc_q} + {mul_p[63], mul_p[63:0]};
		else            acc_next = {acc_q[63], acc_q} - {mul_p[63], mul_p[63:0]};
		if (acc_next[64] != acc_next[63])
			acc_sat = acc_next[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		else
			acc_sat = acc_next[63:0];
		rnd = $signed({acc_q[63], acc_q[63:30]}) + $signed({34'b0, acc_q[29]});
		if (rnd[34:31] != {4{rnd[31]}})
			y_sat = rnd[34] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		else
			y_sat = rnd[31:0];
		csum_next  = {1'b0, csum_q[ch_q]} + {12'b0, mul_p[63:11]};
		total_next = {1'b0, total_q} + {1'b0, csum_q[idx_q]};
		bp_c  = (prod_q[111:96] != '0) ? {POWER_W{1'b1}} : prod_q[95:48];
		evict = (fill_q == FILL_W'(SHORT_TERM_BLOCKS)) ? hist_q[head_q] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			fcnt_q      <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			hsum_q      <= '0;
			for (int s = 0; s < 2; s++)
				for (int c = 0; c < MAX_CHANNELS; c++)
					for (int d = 0; d < 4; d++) dly_q[s][c][d] <= '0;
			for (int c = 0; c < MAX_CHANNELS; c++) csum_q[c] <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && ({1'b0, in_data.channel} < nch)) begin
						state_q <= ST_BQ_MUL;
					end
				end
				ST_BQ_MUL: state_q <= ST_BQ_ACC;
				ST_BQ_ACC: state_q <= (k_q == 3'd4) ? ST_BQ_RND : ST_BQ_MUL;
				ST_BQ_RND: begin
					dly_q[stg_q][ch_q][1] <= dly_q[stg_q][ch_q][0];
					dly_q[stg_q][ch_q][0] <= xin_q;
					dly_q[stg_q][ch_q][3] <= dly_q[stg_q][ch_q][2];
					dly_q[stg_q][ch_q][2] <= y_sat;
					state_q <= stg_q ? ST_SQ_MUL : ST_BQ_MUL;
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					csum_q[ch_q] <= csum_next[64] ? '1 : csum_next[63:0];
					if (CHCNT_W'(ch_q) == nch - 1'b1) begin
						if ((fcnt_q + 1'b1) < frames_eff) begin
							fcnt_q  <= fcnt_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							fcnt_q  <= '0;
							state_q <= ST_SUM;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (CHCNT_W'(idx_q) == nch - 1'b1) begin
						for (int c = 0; c < MAX_CHANNELS; c++) csum_q[c] <= '0;
						state_q <= ST_PW_MUL;
					end
				end
				ST_PW_MUL: state_q <= ST_PW_ACC;
				ST_PW_ACC: state_q <= (pp_q == 2'd3) ? ST_HIST : ST_PW_MUL;
				ST_HIST: begin
					hsum_q <= hsum_q + SUM_W'(bp_c) - SUM_W'(evict);
					head_q <= (head_q == HD_W'(SHORT_TERM_BLOCKS - 1)) ? '0 : head_q + 1'b1;
					if (fill_q != FILL_W'(SHORT_TERM_BLOCKS)) fill_q <= fill_q + 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dv_ctl.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q  <= in_data.channel[CH_W-1:0];
				xin_q <= x_conv;
				stg_q <= 1'b0;
				k_q   <= '0;
				acc_q <= '0;
			end
			ST_BQ_ACC: begin
				acc_q <= acc_sat;
				k_q   <= k_q + 1'b1;
			end
			ST_BQ_RND: begin
				xin_q <= y_sat;
				stg_q <= 1'b1;
				k_q   <= '0;
				acc_q <= '0;
			end
			ST_SQ_ACC: begin
				idx_q   <= '0;
				total_q <= '0;
			end
			ST_SUM: begin
				total_q <= total_next[64] ? '1 : total_next[63:0];
				idx_q   <= idx_q + 1'b1;
				pp_q    <= '0;
				prod_q  <= '0;
			end
			ST_PW_ACC: begin
				prod_q <= prod_q + ({48'b0, mul_p[63:0]} << (32 * (pp_q[0] + pp_q[1])));
				pp_q   <= pp_q + 1'b1;
			end
			ST_HIST: begin
				hist_q[head_q] <= bp_c;
				bp_q           <= bp_c;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q.block_power      <= bp_q;
					out_q.short_term_power <= dv_quo[POWER_W-1:0];
					out_q.window_fill      <= 4'(fill_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SHORT_TERM_BLOCKS))
		else $error("history fill beyond window depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		dv_ctl.start |-> !dv_ctl.busy)
		else $error("divider restarted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");
endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench of k_weighted_block_loudness_meter
// holds a bit-exact power predictor in a scoreboard class and drives the block with plain tasks
// depends on kwl_pkg and the block's rtl
`timescale 1ns / 100ps

class loudness_scoreboard;
	logic [63:0] regs[8];
	int          xin[2][16];
	int          yout[2][16];
	logic [63:0] ch_sum[8];
	logic [16:0] frame_cnt;
	logic [47:0] history[8];
	int unsigned fill;
	int unsigned head;
	kwl_pkg::out_t exp_mem[int];
	int          wr_ptr;
	int          rd_ptr;
	int unsigned errors;

	function void clear();
		foreach (regs[i]) regs[i] = '0;
		regs[kwl_pkg::REG_BLOCK_FRAMES]  = 64'(kwl_pkg::FRAMES_RST);
		regs[kwl_pkg::REG_CHANNELS]      = 64'(kwl_pkg::CHCNT_RST);
		regs[kwl_pkg::REG_INVERSE_SCALE] = 64'(kwl_pkg::INVSCL_RST);
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < 16; i++) begin
				xin[s][i] = 0;
				yout[s][i] = 0;
			end
		foreach (ch_sum[i]) ch_sum[i] = '0;
		foreach (history[i]) history[i] = '0;
		frame_cnt = '0;
		fill = 0;
		head = 0;
		exp_mem.delete();
		wr_ptr = 0;
		rd_ptr = 0;
		errors = 0;
	endfunction

	function int pending();
		return wr_ptr - rd_ptr;
	endfunction

	function void set_reg(kwl_pkg::cfg_reg_e idx, logic [63:0] v);
		regs[idx] = v;
	endfunction

	function longint sat_add(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return longint'(s[63:0]);
	endfunction

	function int biquad(int st, longint c[5], int x, int ch);
		longint acc, q;
		acc = 0;
		acc = sat_add(acc, c[0] * longint'(x));
		acc = sat_add(acc, c[1] * longint'(xin[st][ch*2]));
		acc = sat_add(acc, c[2] * longint'(xin[st][ch*2+1]));
		acc = sat_add(acc, -(c[3] * longint'(yout[st][ch*2])));
		acc = sat_add(acc, -(c[4] * longint'(yout[st][ch*2+1])));
		q = (acc >>> 30) + longint'(acc[29]);
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		xin[st][ch*2+1] = xin[st][ch*2];
		xin[st][ch*2] = x;
		yout[st][ch*2+1] = yout[st][ch*2];
		yout[st][ch*2] = int'(q);
		return int'(q);
	endfunction

	function void note_sample(kwl_pkg::in_t d);
		int unsigned nch, frames, ch;
		longint sh[5], hp[5];
		int x, y1, y2;
		logic [63:0] sq, total;
		logic [64:0] wide;
		logic [111:0] prod;
		logic [47:0] bp;
		logic [63:0] hsum;
		kwl_pkg::out_t r;
		nch = regs[kwl_pkg::REG_CHANNELS][3:0];
		if (nch == 0) nch = 1;
		if (nch > 8) nch = 8;
		frames = regs[kwl_pkg::REG_BLOCK_FRAMES][16:0];
		if (frames == 0) frames = 1;
		ch = d.channel;
		if (ch >= nch)
			return;
		x = {{3{d.sample[23]}}, d.sample, 5'b0};
		sh[0] = longint'($signed(regs[kwl_pkg::REG_SHELF_B0_B1][63:32]));
		sh[1] = longint'($signed(regs[kwl_pkg::REG_SHELF_B0_B1][31:0]));
		sh[2] = longint'($signed(regs[kwl_pkg::REG_SHELF_B2_A1][63:32]));
		sh[3] = longint'($signed(regs[kwl_pkg::REG_SHELF_B2_A1][31:0]));
		sh[4] = longint'($signed(regs[kwl_pkg::REG_SHELF_A2_HP_B0][63:32]));
		hp[0] = longint'($signed(regs[kwl_pkg::REG_SHELF_A2_HP_B0][31:0]));
		hp[1] = longint'($signed(regs[kwl_pkg::REG_HP_B1_B2][63:32]));
		hp[2] = longint'($signed(regs[kwl_pkg::REG_HP_B1_B2][31:0]));
		hp[3] = longint'($signed(regs[kwl_pkg::REG_HP_A1_A2][63:32]));
		hp[4] = longint'($signed(regs[kwl_pkg::REG_HP_A1_A2][31:0]));
		y1 = biquad(0, sh, x, ch);
		y2 = biquad(1, hp, y1, ch);
		sq = 64'(longint'(y2) * longint'(y2)) >> 11;
		wide = {1'b0, ch_sum[ch]} + {1'b0, sq};
		ch_sum[ch] = wide[64] ? '1 : wide[63:0];
		if (ch != nch - 1)
			return;
		frame_cnt = frame_cnt + 17'd1;
		if (frame_cnt < frames)
			return;
		total = '0;
		for (int i = 0; i < nch; i++) begin
			wide = {1'b0, total} + {1'b0, ch_sum[i]};
			total = wide[64] ? '1 : wide[63:0];
		end
		foreach (ch_sum[i]) ch_sum[i] = '0;
		frame_cnt = '0;
		prod = 112'(total) * 112'(regs[kwl_pkg::REG_INVERSE_SCALE][47:0]);
		bp = (prod[111:96] != 0) ? '1 : prod[95:48];
		history[head] = bp;
		head = (head + 1) % 8;
		if (fill < 8) fill++;
		hsum = '0;
		for (int k = 0; k < fill; k++)
			hsum += 64'(history[(head + 7 - k) % 8]);
		r.block_power = bp;
		r.short_term_power = 48'(hsum / fill);
		r.window_fill = 4'(fill);
		exp_mem[wr_ptr] = r;
		wr_ptr++;
	endfunction

	function void check_result(kwl_pkg::out_t got);
		kwl_pkg::out_t e;
		if (pending() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result with nothing expected: %h", $realtime, got);
			return;
		end
		e = exp_mem[rd_ptr];
		exp_mem.delete(rd_ptr);
		rd_ptr++;
		if (got.block_power !== e.block_power || got.short_term_power !== e.short_term_power
				|| got.window_fill !== e.window_fill) begin
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch block %h/%h short %h/%h fill %0d/%0d (exp/act)",
					$realtime, e.block_power, got.block_power, e.short_term_power,
					got.short_term_power, e.window_fill, got.window_fill);
		end
	endfunction
endclass

module tb_top;
	import kwl_pkg::*;

	localparam int IDLE_LIMIT = 50000;
	localparam int N_ITEMS    = 1050;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SHELF_B0_B1;
	logic [CFG_W-1:0]     cfg_data = '0;

	loudness_scoreboard sb = new();
	int unsigned n_sent = 0;
	int unsigned n_results = 0;
	int unsigned cur_nch = 2;
	bit          sender_calm = 0;

	k_weighted_block_loudness_meter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] rand_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 24'h7FFFFF;
		if (r == 1) return 24'h800000;
		if (r < 5) return 24'($urandom_range(0, 2000)) - 24'd1000;
		return 24'($urandom);
	endfunction

	task automatic send(logic [23:0] s, logic [2:0] ch);
		int unsigned gap;
		in_t d;
		d.sample = s;
		d.channel = ch;
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		sb.note_sample(d);
		n_sent++;
		gap = sender_calm ? 0 : rand_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_config(logic [63:0] v[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v[i];
			@(posedge clk);
			sb.set_reg(cfg_reg_e'(i), v[i]);
		end
		cfg_we <= 1'b0;
		cur_nch = v[REG_CHANNELS][3:0];
		if (cur_nch == 0) cur_nch = 1;
		if (cur_nch > 8) cur_nch = 8;
	endtask

	task automatic pick_config(int cmode, output logic [63:0] v[8]);
		int c[10];
		int unsigned f, n;
		for (int i = 0; i < 10; i++) begin
			case (cmode)
				0: c[i] = int'($urandom);
				1: c[i] = int'($urandom_range(0, 1 << 27)) - (1 << 26);
				default: c[i] = 0;
			endcase
		end
		if (cmode != 0) begin
			c[0] += 1 << 30;
			c[5] += 1 << 30;
		end
		v[REG_SHELF_B0_B1]    = {c[0], c[1]};
		v[REG_SHELF_B2_A1]    = {c[2], c[3]};
		v[REG_SHELF_A2_HP_B0] = {c[4], c[5]};
		v[REG_HP_B1_B2]       = {c[6], c[7]};
		v[REG_HP_A1_A2]       = {c[8], c[9]};
		f = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
		v[REG_BLOCK_FRAMES] = 64'(f);
		v[REG_CHANNELS] = 64'(n);
		case ($urandom_range(0, 5))
			0: v[REG_INVERSE_SCALE] = 64'(48'hFFFF_FFFF_FFFF);
			1: v[REG_INVERSE_SCALE] = '0;
			2: v[REG_INVERSE_SCALE] = 64'($urandom) << 16 | 64'($urandom_range(0, 65535));
			default: v[REG_INVERSE_SCALE] = 64'(48'hFFFF_FFFF_FFFF / ((f == 0 ? 1 : f) *
				(n == 0 ? 1 : (n > 8 ? 8 : n))));
		endcase
	endtask

	task automatic send_frames(int unsigned frames, bit noisy);
		for (int f = 0; f < frames; f++)
			for (int ch = 0; ch < cur_nch; ch++) begin
				if (n_sent >= N_ITEMS)
					return;
				if (noisy && $urandom_range(0, 9) == 0)
					send(rand_sample(), 3'($urandom_range(0, 7)));
				send(rand_sample(), 3'(ch));
			end
	endtask

	// receiver with random stalls and two long hold-offs
	initial begin
		int unsigned hold, stall_left, calm_left;
		hold = 0;
		stall_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(out_data);
				n_results++;
				if (n_results == 40 || n_results == 300)
					hold = 500;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (calm_left != 0) begin
				out_stall <= 1'b0;
				calm_left--;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = rand_gap();
				if ($urandom_range(0, 9) == 0)
					calm_left = $urandom_range(20, 80);
			end
		end
	end

	// watchdog on cycles without any request or result moving
	initial begin
		int unsigned idle, last_sent, last_res;
		idle = 0;
		last_sent = 0;
		last_res = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (n_sent != last_sent || n_results != last_res)
				idle = 0;
			else
				idle++;
			last_sent = n_sent;
			last_res = n_results;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		logic [63:0] v[8];
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero coefficients, long block, no result
		send(24'h7FFFFF, 3'd0);
		send(24'h800000, 3'd1);
		send(24'h000001, 3'd7);
		drain();

		// unity filters, one frame per block, full scale reciprocal
		pick_config(2, v);
		v[REG_BLOCK_FRAMES] = 64'd1;
		v[REG_CHANNELS] = 64'd1;
		v[REG_INVERSE_SCALE] = 64'(48'hFFFF_FFFF_FFFF);
		write_config(v);
		send(24'h7FFFFF, 3'd0);
		send(24'h800000, 3'd0);
		send(24'h000000, 3'd0);
		send(24'hFFFFFF, 3'd0);
		send(24'h555555, 3'd5);
		send(24'hAAAAAA, 3'd0);
		drain();

		// channel count and block length of zero, saturating coefficients
		pick_config(0, v);
		v[REG_BLOCK_FRAMES] = 64'd0;
		v[REG_CHANNELS] = 64'd0;
		write_config(v);
		send(24'h7FFFFF, 3'd0);
		send(24'h800000, 3'd0);
		send(24'h7FFFFF, 3'd1);
		send(24'h800000, 3'd0);
		drain();

		// channel count above range, zero reciprocal
		pick_config(1, v);
		v[REG_BLOCK_FRAMES] = 64'd2;
		v[REG_CHANNELS] = 64'd15;
		v[REG_INVERSE_SCALE] = '0;
		write_config(v);
		send_frames(2, 0);
		drain();

		// longest block, then shortened while a block is open
		pick_config(1, v);
		v[REG_BLOCK_FRAMES] = 64'd131071;
		v[REG_CHANNELS] = 64'd3;
		write_config(v);
		send_frames(3, 0);
		drain();
		v[REG_BLOCK_FRAMES] = 64'd1;
		write_config(v);
		send_frames(2, 0);
		drain();

		while (n_sent < N_ITEMS) begin
			pick_config($urandom_range(0, 3) == 0 ? 0 : 1, v);
			write_config(v);
			sender_calm = ($urandom_range(0, 3) == 0);
			send_frames($urandom_range(8, 30), $urandom_range(0, 2) == 0);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
